[design/wjos_pkg.sv]
// Shared types and constants for the weighted job order scheduler.
`default_nettype none

package wjos_pkg;

    localparam int DUR_W    = 16;
    localparam int PEN_W    = 16;
    localparam int JOBNUM_W = 7;
    localparam int COST_W   = 45;
    localparam int WAIT_W   = 23;
    localparam int RATIO_W  = DUR_W + PEN_W;
    localparam int PROD_W   = WAIT_W + DUR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RETIRE,
        ST_MUL,
        ST_EMIT
    } wjos_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // store the incoming job
        logic start;    // begin ordering a new set
        logic scan;     // step the selection scan
        logic retire;   // take the selected job out of the waiting set
        logic mul;      // form duration times waiting penalty
        logic emit;     // load the result register
    } wjos_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic last_job;
    } wjos_sts_t;

endpackage

`default_nettype wire

[design/wjos_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module wjos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/wjos_dpath.sv]
// Datapath: job store, selection scan, cost arithmetic and result register.
`default_nettype none

module wjos_dpath import wjos_pkg::*; #(
    parameter int MAX_JOBS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [DUR_W-1:0]    s_duration,
    input  wire logic [PEN_W-1:0]    s_daily_penalty,
    input  wire wjos_cmd_t           cmd,
    output wjos_sts_t                sts,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [JOBNUM_W-1:0]      m_job_number,
    output logic [COST_W-1:0]        m_running_cost,
    output logic                     m_last_result
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [WAIT_W-1:0]    waiting_reg, waiting_next;
    logic [COST_W-1:0]    cost_reg, cost_next;
    logic [MAX_JOBS-1:0]  served_reg, served_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     emit_cnt_reg, emit_cnt_next;
    logic                 cand_vld_reg, cand_vld_next;
    logic [IDX_W-1:0]     cand_idx_reg, cand_idx_next;
    logic                 best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [DUR_W-1:0]     best_dur_reg, best_dur_next;
    logic [PEN_W-1:0]     best_pen_reg, best_pen_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 m_valid_reg, m_valid_next;
    logic [JOBNUM_W-1:0]  job_number_reg, job_number_next;
    logic [COST_W-1:0]    out_cost_reg, out_cost_next;
    logic                 out_last_reg, out_last_next;

    logic                 room;
    logic                 ram_we;
    logic                 ram_re;
    logic [RATIO_W-1:0]   ram_q;
    logic [DUR_W-1:0]     cand_dur;
    logic [PEN_W-1:0]     cand_pen;
    logic [RATIO_W-1:0]   lhs;
    logic [RATIO_W-1:0]   rhs;
    logic                 cand_first;
    logic                 last_job;

    assign room   = count_reg < CNT_W'(MAX_JOBS);
    assign ram_we = cmd.load && room;
    assign ram_re = cmd.scan && (scan_reg != count_reg);

    wjos_ram #(
        .WIDTH (RATIO_W),
        .DEPTH (MAX_JOBS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({s_duration, s_daily_penalty}),
        .re    (ram_re),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_q)
    );

    assign cand_dur = ram_q[RATIO_W-1:PEN_W];
    assign cand_pen = ram_q[PEN_W-1:0];

    // ratio compare by cross-multiplication; candidate always has the higher index
    assign lhs = RATIO_W'(cand_pen) * RATIO_W'(best_dur_reg);
    assign rhs = RATIO_W'(best_pen_reg) * RATIO_W'(cand_dur);

    always_comb begin
        if (cand_dur == '0) begin
            cand_first = (best_dur_reg != '0);
        end else if (best_dur_reg == '0) begin
            cand_first = 1'b0;
        end else begin
            cand_first = lhs > rhs;
        end
    end

    assign last_job = (emit_cnt_reg + CNT_W'(1)) == count_reg;

    always_comb begin
        count_next      = count_reg;
        waiting_next    = waiting_reg;
        cost_next       = cost_reg;
        served_next     = served_reg;
        scan_next       = scan_reg;
        emit_cnt_next   = emit_cnt_reg;
        cand_vld_next   = 1'b0;
        cand_idx_next   = scan_reg[IDX_W-1:0];
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_dur_next   = best_dur_reg;
        best_pen_next   = best_pen_reg;
        prod_next       = prod_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        job_number_next = job_number_reg;
        out_cost_next   = out_cost_reg;
        out_last_next   = out_last_reg;

        if (ram_we) begin
            count_next   = count_reg + CNT_W'(1);
            waiting_next = waiting_reg + WAIT_W'(s_daily_penalty);
        end

        if (cmd.start) begin
            served_next   = '0;
            emit_cnt_next = '0;
        end
        if (cmd.start || cmd.emit) begin
            scan_next     = '0;
            best_vld_next = 1'b0;
        end

        if (ram_re) begin
            scan_next     = scan_reg + CNT_W'(1);
            cand_vld_next = 1'b1;
        end

        if (cand_vld_reg && !served_reg[cand_idx_reg] && (!best_vld_reg || cand_first)) begin
            best_vld_next = 1'b1;
            best_idx_next = cand_idx_reg;
            best_dur_next = cand_dur;
            best_pen_next = cand_pen;
        end

        if (cmd.retire) begin
            waiting_next              = waiting_reg - WAIT_W'(best_pen_reg);
            served_next[best_idx_reg] = 1'b1;
        end

        if (cmd.mul) begin
            prod_next = PROD_W'(waiting_reg) * PROD_W'(best_dur_reg);
        end

        if (cmd.emit) begin
            m_valid_next    = 1'b1;
            job_number_next = JOBNUM_W'(best_idx_reg) + JOBNUM_W'(1);
            out_cost_next   = cost_reg + COST_W'(prod_reg);
            out_last_next   = last_job;
            emit_cnt_next   = emit_cnt_reg + CNT_W'(1);
            cost_next       = out_cost_next;
            if (last_job) begin
                count_next   = '0;
                waiting_next = '0;
                cost_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            waiting_reg  <= '0;
            cost_reg     <= '0;
            cand_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            waiting_reg  <= waiting_next;
            cost_reg     <= cost_next;
            cand_vld_reg <= cand_vld_next;
            best_vld_reg <= best_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        served_reg     <= served_next;
        scan_reg       <= scan_next;
        emit_cnt_reg   <= emit_cnt_next;
        cand_idx_reg   <= cand_idx_next;
        best_idx_reg   <= best_idx_next;
        best_dur_reg   <= best_dur_next;
        best_pen_reg   <= best_pen_next;
        prod_reg       <= prod_next;
        job_number_reg <= job_number_next;
        out_cost_reg   <= out_cost_next;
        out_last_reg   <= out_last_next;
    end

    assign sts.scan_done = (scan_reg == count_reg) && !cand_vld_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.last_job  = last_job;

    assign m_valid        = m_valid_reg;
    assign m_job_number   = job_number_reg;
    assign m_running_cost = out_cost_reg;
    assign m_last_result  = out_last_reg;

endmodule

`default_nettype wire

[design/wjos_ctrl.sv]
// Controller state machine: load, select, retire, multiply, emit.
`default_nettype none

module wjos_ctrl import wjos_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_final_job,
    output logic            s_ready,
    input  wire wjos_sts_t  sts,
    output wjos_cmd_t       cmd
);

    wjos_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_final_job) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_RETIRE;
                end
            end
            ST_RETIRE: begin
                cmd.retire = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_job ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/weighted_job_order_scheduler.sv]
// Top level of the weighted job order scheduler.
//
// Input channel s_*: one job per transfer (duration, daily penalty, final flag).
// Jobs are stored in arrival order, numbered from 1; jobs beyond MAX_JOBS are
// dropped. A job with s_final_job set closes the set and starts scheduling;
// s_ready stays low until the last result of that set sits in the output register.
// Result channel m_*: one transfer per stored job in service order (highest
// penalty/duration ratio first, ties to the lower job number), with the running
// cost; m_last_result marks the final cost of the set.
// Timing: a non-final job does not close the input, so jobs stream back to back. Each
// result needs one selection scan over the n stored jobs through the job RAM's
// single read port, followed by the retire, multiply and emit steps.
// A stalled receiver holds the result register; the scan for the next result
// runs on and waits in the emit step. After the last result is loaded, new jobs
// are taken while that result still waits.
// Reset (aresetn, synchronous, active low) empties the job set and clears the
// result channel.
`default_nettype none

module weighted_job_order_scheduler import wjos_pkg::*; #(
    parameter int MAX_JOBS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [DUR_W-1:0]    s_duration,
    input  wire logic [PEN_W-1:0]    s_daily_penalty,
    input  wire logic                s_final_job,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [JOBNUM_W-1:0]      m_job_number,
    output logic [COST_W-1:0]        m_running_cost,
    output logic                     m_last_result
);

    wjos_cmd_t cmd;
    wjos_sts_t sts;

    wjos_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_final_job (s_final_job),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    wjos_dpath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_duration      (s_duration),
        .s_daily_penalty (s_daily_penalty),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_job_number    (m_job_number),
        .m_running_cost  (m_running_cost),
        .m_last_result   (m_last_result)
    );

endmodule

`default_nettype wire

[design/wjos_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
`default_nettype none

module wjos_checker import wjos_pkg::*; #(
    parameter int MAX_JOBS = 64
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                s_final_job,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [JOBNUM_W-1:0] m_job_number,
    input wire logic [COST_W-1:0]   m_running_cost,
    input wire logic                m_last_result
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_job_number)
            && $stable(m_running_cost) && $stable(m_last_result))
        else $error("result changed while stalled");

    a_jobnum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_job_number != '0 && m_job_number <= JOBNUM_W'(MAX_JOBS))
        else $error("job number out of range");

    // a final job closes the input until its set is scheduled
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_job |=> !s_ready)
        else $error("input open right after final job");

    // mid-schedule results never coexist with an open input
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_result |-> !s_ready)
        else $error("input open during schedule");

endmodule

bind weighted_job_order_scheduler wjos_checker #(.MAX_JOBS(MAX_JOBS)) u_wjos_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_final_job    (s_final_job),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_job_number   (m_job_number),
    .m_running_cost (m_running_cost),
    .m_last_result  (m_last_result)
);

`default_nettype wire

[dv/weighted_job_order_scheduler_tb.sv]
// Self-checking testbench for the weighted job order scheduler: directed table plus random job sets.
module weighted_job_order_scheduler_tb;
    import wjos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOB_SLOTS  = 64;
    localparam int QUIET_MAX  = 4000;   // cycles with no transfer on either channel
    localparam int HOLD_LEN   = 400;    // long receiver hold-off to back up the input
    localparam int HOLD_AT    = 12;     // result count that triggers the hold-off
    localparam int RAND_ITEMS = 164;
    localparam int NUM_ROWS   = 16;

    typedef struct {
        logic [JOBNUM_W-1:0] job_number;
        logic [COST_W-1:0]   running_cost;
        logic                last_result;
    } sched_result_t;

    typedef struct packed {
        logic [DUR_W-1:0]    dur;
        logic [PEN_W-1:0]    pen;
        logic                fin;
        logic                typed;     // expected result given in the row
        logic [JOBNUM_W-1:0] want_job;
        logic [COST_W-1:0]   want_cost;
        logic                want_last;
    } stim_row_t;

    localparam stim_row_t STIM_TABLE [NUM_ROWS] = '{
        // single-job sets: job 1, nothing left waiting, zero cost
        '{16'd1,     16'd0,     1'b1, 1'b1, 7'd1, 45'd0, 1'b1},
        '{16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 7'd1, 45'd0, 1'b1},
        '{16'd0,     16'd0,     1'b1, 1'b1, 7'd1, 45'd0, 1'b1},
        // equal ratios and zero durations mixed in one set
        '{16'd2,     16'd4,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'd0,     16'd9,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'd1,     16'd2,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'd0,     16'd0,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'd3,     16'd6,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'hFFFF,  16'hFFFF,  1'b1, 1'b0, 7'd0, 45'd0, 1'b0},
        // extreme ratios
        '{16'hFFFF,  16'd1,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'd1,     16'hFFFF,  1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'hFFFF,  16'd0,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'd1,     16'd0,     1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'd40000, 16'hFFFF,  1'b1, 1'b0, 7'd0, 45'd0, 1'b0},
        // alternating bit patterns
        '{16'h5555,  16'hAAAA,  1'b0, 1'b0, 7'd0, 45'd0, 1'b0},
        '{16'hAAAA,  16'h5555,  1'b1, 1'b0, 7'd0, 45'd0, 1'b0}
    };

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [DUR_W-1:0]    s_duration      = '0;
    logic [PEN_W-1:0]    s_daily_penalty = '0;
    logic                s_final_job     = 1'b0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [JOBNUM_W-1:0] m_job_number;
    logic [COST_W-1:0]   m_running_cost;
    logic                m_last_result;

    weighted_job_order_scheduler #(.MAX_JOBS(JOB_SLOTS)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_duration      (s_duration),
        .s_daily_penalty (s_daily_penalty),
        .s_final_job     (s_final_job),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_job_number    (m_job_number),
        .m_running_cost  (m_running_cost),
        .m_last_result   (m_last_result)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Scheduler mirror: held jobs, penalty still waiting, running cost
    logic [DUR_W-1:0]  held_days [JOB_SLOTS];
    logic [PEN_W-1:0]  held_fine [JOB_SLOTS];
    int unsigned       held_count = 0;
    logic [WAIT_W-1:0] fine_pool  = '0;
    logic [COST_W-1:0] cost_sum   = '0;

    sched_result_t due_results [$];

    int errors       = 0;
    int jobs_sent    = 0;
    int jobs_dropped = 0;
    int sets_closed  = 0;
    int results_seen = 0;
    bit send_burst   = 1'b0;
    bit recv_burst   = 1'b0;

    // true when job a is served before job b
    function automatic bit goes_ahead(int a, int b);
        logic [31:0] lhs;
        logic [31:0] rhs;
        if (held_days[a] == 0 || held_days[b] == 0) begin
            if (held_days[a] == 0 && held_days[b] != 0)
                return 1'b1;
            if (held_days[b] == 0 && held_days[a] != 0)
                return 1'b0;
            return a < b;
        end
        lhs = held_fine[a] * held_days[b];
        rhs = held_fine[b] * held_days[a];
        if (lhs != rhs)
            return lhs > rhs;
        return a < b;
    endfunction

    task automatic schedule_job(input logic [DUR_W-1:0] dur, input logic [PEN_W-1:0] pen,
                                input logic fin, input bit keep_results);
        int rank [JOB_SLOTS];
        int n;
        int j;
        logic [COST_W-1:0] step_cost;
        sched_result_t r;
        if (held_count < JOB_SLOTS) begin
            held_days[held_count] = dur;
            held_fine[held_count] = pen;
            held_count++;
            fine_pool = fine_pool + pen;
        end else begin
            jobs_dropped++;
        end
        if (!fin)
            return;
        n = held_count;
        for (int i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && goes_ahead(i, rank[j-1])) begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = i;
        end
        for (int k = 0; k < n; k++) begin
            fine_pool = fine_pool - held_fine[rank[k]];
            step_cost = fine_pool * held_days[rank[k]];
            cost_sum = cost_sum + step_cost;
            r.job_number   = JOBNUM_W'(rank[k] + 1);
            r.running_cost = cost_sum;
            r.last_result  = (k == n - 1);
            if (keep_results)
                due_results.push_back(r);
        end
        held_count  = 0;
        fine_pool   = '0;
        cost_sum    = '0;
        sets_closed++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(1, 6));
            default: return 16'($urandom);
        endcase
    endfunction

    // Called at a clock edge; returns at the edge where the job transfers.
    task automatic offer_job(input logic [DUR_W-1:0] dur, input logic [PEN_W-1:0] pen,
                             input logic fin, input stim_row_t row);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_duration      <= dur;
        s_daily_penalty <= pen;
        s_final_job     <= fin;
        do @(posedge aclk); while (!s_ready);
        jobs_sent++;
        if (row.typed) begin
            due_results.push_back('{row.want_job, row.want_cost, row.want_last});
            schedule_job(dur, pen, fin, 1'b0);
        end else begin
            schedule_job(dur, pen, fin, 1'b1);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: job_number %0d running_cost %0d",
                       m_job_number, m_running_cost);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (m_job_number !== want.job_number) begin
                    $error("job_number: expected %0d, got %0d", want.job_number, m_job_number);
                    errors++;
                end
                if (m_running_cost !== want.running_cost) begin
                    $error("running_cost: expected %0d, got %0d",
                           want.running_cost, m_running_cost);
                    errors++;
                end
                if (m_last_result !== want.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, m_last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog on stretches with no transfer at all
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_MAX) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result receiver
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 19) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 18);
            if (results_seen == HOLD_AT)
                stall = HOLD_LEN;    // let the block back up and stall its input
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
        end
    end

    // Job sender and end of run
    initial begin
        stim_row_t row;
        int sent_random;
        int set_size;
        bit big_done;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = STIM_TABLE[r];
            offer_job(row.dur, row.pen, row.fin, row);
        end

        row = '0;
        sent_random = 0;
        big_done = 1'b0;
        while (sent_random < RAND_ITEMS) begin
            if (!big_done && sent_random >= 40) begin
                set_size = JOB_SLOTS + 6;    // overflows the store, final job dropped too
                big_done = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                set_size = $urandom_range(9, 20);
            end else begin
                set_size = $urandom_range(1, 8);
            end
            for (int k = 0; k < set_size; k++)
                offer_job(pick_value(), pick_value(), k == set_size - 1, row);
            sent_random += set_size;
        end
        s_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d jobs in %0d sets (%0d dropped on a full store), %0d results checked.",
                 jobs_sent, sets_closed, jobs_dropped, results_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
